// File: design/tribary_pkg.sv
// ----------------------------------------------------------------------------
// Triangle barycentric package
// Register indexes, lane numbering and fixed sizes shared by the design.
// ----------------------------------------------------------------------------
package tribary_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int NUM_REGS    = 6;
   localparam int NUM_VERTS   = 3;
   localparam int NUM_LANES   = 6;   // square-root lanes
   localparam int NUM_DETS    = 3;
   localparam int NUM_DIVS    = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_V0X = 3'd0,
      REG_V0Y = 3'd1,
      REG_V1X = 3'd2,
      REG_V1Y = 3'd3,
      REG_V2X = 3'd4,
      REG_V2Y = 3'd5
   } csr_reg_type;

   // square-root lanes: three point-to-vertex distances, then three sides
   localparam int LANE_D0  = 0;
   localparam int LANE_S01 = 3;
   localparam int LANE_S02 = 4;
   localparam int LANE_S12 = 5;

   // side vectors
   localparam int SIDE_01 = 0;
   localparam int SIDE_02 = 1;
   localparam int SIDE_12 = 2;

   // determinants: full triangle, then the two weight numerators
   localparam int DET_FULL = 0;
   localparam int DET_W0   = 1;
   localparam int DET_W1   = 2;

endpackage

// File: design/triangle_barycentric_and_metrics.sv
// ----------------------------------------------------------------------------
// Triangle barycentric weights and metrics
// Streams query points against a configured triangle and returns weights,
// vertex distances, doubled area, perimeter and a zero-area flag.
// ----------------------------------------------------------------------------
// Load the six vertex coordinates through the csr_ port while no transfer is
// in flight, then stream points at one per cycle. The pipeline depth is set
// by the longer of the restoring quotient chain, which resolves one weight
// bit per stage, and the square-root chain running beside it, which resolves
// one root bit per stage. Every stage carries its own valid bit and takes a
// new item whenever it is empty or its successor moves, so bubbles collapse
// and the input keeps taking points while the output register holds a result
// that waits, as long as an empty stage remains. Weights 0 and 1 are
// floor(|det| * 2^F / twice-area), saturated; weight 2 is one minus both,
// clamped. A zero-area triangle raises rsp_tuser and zeros all weights.
// ----------------------------------------------------------------------------
module triangle_barycentric_and_metrics #(
   parameter int COORD_BITS       = 16,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // point_x, point_y from the lowest bit up
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // weight0, weight1, weight2, dist0, dist1, dist2, area_doubled, perimeter
   output logic [((3*(WEIGHT_FRAC_BITS+3)+3*(COORD_BITS+2)+(2*COORD_BITS+4)
                  +(COORD_BITS+4)+7)/8)*8-1:0]   rsp_tdata,
   // degenerate
   output logic                                  rsp_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_wen,
   input  logic [tribary_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [COORD_BITS-1:0]                 csr_wdata
);

   localparam int C        = COORD_BITS;
   localparam int F        = WEIGHT_FRAC_BITS;
   localparam int DELTA_W  = C + 1;
   localparam int PROD_W   = 2*C + 2;
   localparam int SQ_W     = 2*C + 2;
   localparam int ROOT_W   = C + 1;
   localparam int DET_W    = 2*C + 3;
   localparam int AREA_W   = 2*C + 4;
   localparam int DEN_W    = AREA_W + 1;
   localparam int REM_W    = AREA_W + 2;
   localparam int QUO_W    = F + 2;
   localparam int WEIGHT_W = F + 3;
   localparam int W2_W     = F + 5;
   localparam int DIST_W   = C + 2;
   localparam int PERIM_W  = C + 4;
   localparam int SQRT_N   = C + 1;
   localparam int CORE_N   = (SQRT_N > QUO_W) ? SQRT_N : QUO_W;
   localparam int CORE0    = 5;
   localparam int FIN      = CORE0 + CORE_N;
   localparam int STAGES   = FIN + 1;
   localparam int FIELDS_W = 3*WEIGHT_W + 3*DIST_W + AREA_W + PERIM_W;
   localparam int OUT_W    = ((FIELDS_W + 7) / 8) * 8;
   localparam int NL       = tribary_pkg::NUM_LANES;
   localparam int NV       = tribary_pkg::NUM_VERTS;
   localparam int ND       = tribary_pkg::NUM_DETS;
   localparam int NQ       = tribary_pkg::NUM_DIVS;

   localparam logic signed [WEIGHT_W-1:0] WMAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
   localparam logic signed [W2_W-1:0]     W2_MAX = W2_W'(WMAX);
   localparam logic signed [W2_W-1:0]     W2_MIN = -(W2_W'(WMAX) + W2_W'(1));
   localparam logic signed [W2_W-1:0]     ONE_W  = W2_W'(1) << F;

   // ---------------------------------------------------------------- vertices
   logic signed [C-1:0] vert_ff [tribary_pkg::NUM_REGS];

   // Take a register write; drop unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tribary_pkg::NUM_REGS; i++) vert_ff[i] <= '0;
      end else if (csr_wen) begin
         unique case (tribary_pkg::csr_reg_type'(csr_index))
            tribary_pkg::REG_V0X: vert_ff[0] <= csr_wdata;
            tribary_pkg::REG_V0Y: vert_ff[1] <= csr_wdata;
            tribary_pkg::REG_V1X: vert_ff[2] <= csr_wdata;
            tribary_pkg::REG_V1Y: vert_ff[3] <= csr_wdata;
            tribary_pkg::REG_V2X: vert_ff[4] <= csr_wdata;
            tribary_pkg::REG_V2Y: vert_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------- valid/ready chain
   // A stage loads when it is empty or its successor loads.
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] rdy;

   assign rdy[STAGES-1] = !vld_ff[STAGES-1] || rsp_tready;
   for (genvar s = 0; s < STAGES - 1; s++) begin : g_rdy
      assign rdy[s] = !vld_ff[s] || rdy[s+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= req_tvalid;
         for (int s = 1; s < STAGES; s++) begin
            if (rdy[s]) vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   assign req_tready = rdy[0];

   // ------------------------------------------------------ stage 0: capture
   logic signed [C-1:0] px0_ff, py0_ff;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         px0_ff <= req_tdata[C-1:0];
         py0_ff <= req_tdata[2*C-1:C];
      end
   end

   // ------------------------------------------------------ stage 1: deltas
   logic signed [DELTA_W-1:0] ex1_in [NV], ey1_in [NV], sx1_in [NV], sy1_in [NV];
   logic signed [DELTA_W-1:0] ex1_ff [NV], ey1_ff [NV], sx1_ff [NV], sy1_ff [NV];

   always_comb begin
      for (int k = 0; k < NV; k++) begin
         ex1_in[k] = DELTA_W'(vert_ff[2*k])   - DELTA_W'(px0_ff);
         ey1_in[k] = DELTA_W'(vert_ff[2*k+1]) - DELTA_W'(py0_ff);
      end
      sx1_in[tribary_pkg::SIDE_01] = DELTA_W'(vert_ff[2]) - DELTA_W'(vert_ff[0]);
      sy1_in[tribary_pkg::SIDE_01] = DELTA_W'(vert_ff[3]) - DELTA_W'(vert_ff[1]);
      sx1_in[tribary_pkg::SIDE_02] = DELTA_W'(vert_ff[4]) - DELTA_W'(vert_ff[0]);
      sy1_in[tribary_pkg::SIDE_02] = DELTA_W'(vert_ff[5]) - DELTA_W'(vert_ff[1]);
      sx1_in[tribary_pkg::SIDE_12] = DELTA_W'(vert_ff[4]) - DELTA_W'(vert_ff[2]);
      sy1_in[tribary_pkg::SIDE_12] = DELTA_W'(vert_ff[5]) - DELTA_W'(vert_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         ex1_ff <= ex1_in;
         ey1_ff <= ey1_in;
         sx1_ff <= sx1_in;
         sy1_ff <= sy1_in;
      end
   end

   // ------------------------------------------------------ stage 2: products
   logic signed [DELTA_W-1:0] lx [NL], ly [NL];
   logic signed [PROD_W-1:0]  sqx2_in [NL], sqy2_in [NL], pa2_in [ND], pb2_in [ND];
   logic signed [PROD_W-1:0]  sqx2_ff [NL], sqy2_ff [NL], pa2_ff [ND], pb2_ff [ND];

   always_comb begin
      for (int k = 0; k < NV; k++) begin
         lx[tribary_pkg::LANE_D0+k] = ex1_ff[k];
         ly[tribary_pkg::LANE_D0+k] = ey1_ff[k];
      end
      lx[tribary_pkg::LANE_S01] = sx1_ff[tribary_pkg::SIDE_01];
      ly[tribary_pkg::LANE_S01] = sy1_ff[tribary_pkg::SIDE_01];
      lx[tribary_pkg::LANE_S02] = sx1_ff[tribary_pkg::SIDE_02];
      ly[tribary_pkg::LANE_S02] = sy1_ff[tribary_pkg::SIDE_02];
      lx[tribary_pkg::LANE_S12] = sx1_ff[tribary_pkg::SIDE_12];
      ly[tribary_pkg::LANE_S12] = sy1_ff[tribary_pkg::SIDE_12];
      for (int l = 0; l < NL; l++) begin
         sqx2_in[l] = PROD_W'(lx[l]) * PROD_W'(lx[l]);
         sqy2_in[l] = PROD_W'(ly[l]) * PROD_W'(ly[l]);
      end
      pa2_in[tribary_pkg::DET_FULL] = PROD_W'(sx1_ff[tribary_pkg::SIDE_01])
                                    * PROD_W'(sy1_ff[tribary_pkg::SIDE_02]);
      pb2_in[tribary_pkg::DET_FULL] = PROD_W'(sy1_ff[tribary_pkg::SIDE_01])
                                    * PROD_W'(sx1_ff[tribary_pkg::SIDE_02]);
      pa2_in[tribary_pkg::DET_W0]   = PROD_W'(ex1_ff[2]) * PROD_W'(ey1_ff[1]);
      pb2_in[tribary_pkg::DET_W0]   = PROD_W'(ey1_ff[2]) * PROD_W'(ex1_ff[1]);
      pa2_in[tribary_pkg::DET_W1]   = PROD_W'(ex1_ff[2]) * PROD_W'(ey1_ff[0]);
      pb2_in[tribary_pkg::DET_W1]   = PROD_W'(ey1_ff[2]) * PROD_W'(ex1_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         sqx2_ff <= sqx2_in;
         sqy2_ff <= sqy2_in;
         pa2_ff  <= pa2_in;
         pb2_ff  <= pb2_in;
      end
   end

   // ------------------------------------------------ stage 3: sums, differences
   logic [SQ_W-1:0]         lsq3_in [NL], lsq3_ff [NL];
   logic signed [DET_W-1:0] det3_in [ND], det3_ff [ND];

   always_comb begin
      for (int l = 0; l < NL; l++) lsq3_in[l] = SQ_W'(sqx2_ff[l]) + SQ_W'(sqy2_ff[l]);
      for (int d = 0; d < ND; d++) det3_in[d] = DET_W'(pa2_ff[d]) - DET_W'(pb2_ff[d]);
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         lsq3_ff <= lsq3_in;
         det3_ff <= det3_in;
      end
   end

   // ------------------------------------------------------ stage 4: magnitudes
   logic [AREA_W-1:0] mag4_in [ND], mag4_ff [ND];
   logic [SQ_W-1:0]   lsq4_ff [NL];

   always_comb begin
      for (int d = 0; d < ND; d++) begin
         mag4_in[d] = det3_ff[d][DET_W-1] ? AREA_W'(-det3_ff[d]) : AREA_W'(det3_ff[d]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         mag4_ff <= mag4_in;
         lsq4_ff <= lsq3_ff;
      end
   end

   // ------------------------------------------------------------ core stages
   // Stages resolve one root bit per lane and one quotient bit per weight until
   // each chain ends. The divisor is doubled so the quotient has two integer bits.
   logic [SQ_W-1:0]   rem_ff  [CORE_N][NL], rem_in  [CORE_N][NL];
   logic [ROOT_W-1:0] root_ff [CORE_N][NL], root_in [CORE_N][NL];
   logic [REM_W-1:0]  r_ff    [CORE_N][NQ], r_in    [CORE_N][NQ];
   logic [QUO_W-1:0]  q_ff    [CORE_N][NQ], q_in    [CORE_N][NQ];
   logic              sat_ff  [CORE_N][NQ], sat_in  [CORE_N][NQ];
   logic [DEN_W-1:0]  den_ff  [CORE_N], den_in [CORE_N];
   logic [AREA_W-1:0] area_ff [CORE_N], area_in [CORE_N];

   for (genvar j = 0; j < CORE_N; j++) begin : g_core
      logic [SQ_W-1:0]   rem_src  [NL];
      logic [ROOT_W-1:0] root_src [NL];
      logic [REM_W-1:0]  r_src    [NQ];
      logic [QUO_W-1:0]  q_src    [NQ];
      logic              sat_src  [NQ];
      logic [DEN_W-1:0]  den_src;
      logic [AREA_W-1:0] area_src;

      if (j == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < NL; l++) begin
               rem_src[l]  = lsq4_ff[l];
               root_src[l] = '0;
            end
            for (int i = 0; i < NQ; i++) begin
               r_src[i]   = REM_W'(mag4_ff[tribary_pkg::DET_W0+i]);
               q_src[i]   = '0;
               sat_src[i] = 1'b0;
            end
            den_src  = {mag4_ff[tribary_pkg::DET_FULL], 1'b0};
            area_src = mag4_ff[tribary_pkg::DET_FULL];
         end
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
         assign r_src    = r_ff[j-1];
         assign q_src    = q_ff[j-1];
         assign sat_src  = sat_ff[j-1];
         assign den_src  = den_ff[j-1];
         assign area_src = area_ff[j-1];
      end

      if (j < SQRT_N) begin : g_sqrt
         localparam int BIT = C - j;
         logic [SQ_W:0] test [NL];
         always_comb begin
            for (int l = 0; l < NL; l++) begin
               test[l] = ((SQ_W+1)'(root_src[l]) << (BIT + 1))
                       + ((SQ_W+1)'(1) << (2 * BIT));
               if ({1'b0, rem_src[l]} >= test[l]) begin
                  rem_in[j][l]  = rem_src[l] - SQ_W'(test[l]);
                  root_in[j][l] = root_src[l] | (ROOT_W'(1) << BIT);
               end else begin
                  rem_in[j][l]  = rem_src[l];
                  root_in[j][l] = root_src[l];
               end
            end
         end
      end else begin : g_sqrt_pass
         assign rem_in[j]  = rem_src;
         assign root_in[j] = root_src;
      end

      if (j < QUO_W) begin : g_div
         logic             ge   [NQ];
         logic [REM_W-1:0] diff [NQ];
         always_comb begin
            for (int i = 0; i < NQ; i++) begin
               ge[i]      = r_src[i] >= REM_W'(den_src);
               diff[i]    = ge[i] ? r_src[i] - REM_W'(den_src) : r_src[i];
               r_in[j][i] = diff[i] << 1;
               q_in[j][i] = {q_src[i][QUO_W-2:0], ge[i]};
               // quotient of four or more saturates
               sat_in[j][i] = (j == 0) ? (r_src[i] >= {den_src, 1'b0}) : sat_src[i];
            end
         end
      end else begin : g_div_pass
         assign r_in[j]   = r_src;
         assign q_in[j]   = q_src;
         assign sat_in[j] = sat_src;
      end

      assign den_in[j]  = den_src;
      assign area_in[j] = area_src;

      always_ff @(posedge clock) begin
         if (rdy[CORE0+j]) begin
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
            r_ff[j]    <= r_in[j];
            q_ff[j]    <= q_in[j];
            sat_ff[j]  <= sat_in[j];
            den_ff[j]  <= den_in[j];
            area_ff[j] <= area_in[j];
         end
      end
   end

   // ------------------------------------------------ final stage: output register
   localparam int LAST = CORE_N - 1;

   logic                       degen_in, degen_ff;
   logic signed [WEIGHT_W-1:0] w_in [NQ], w_ff [NQ];
   logic signed [W2_W-1:0]     w2_raw;
   logic signed [WEIGHT_W-1:0] w2_in, w2_ff;
   logic [DIST_W-1:0]          dist_in [NV], dist_ff [NV];
   logic [PERIM_W-1:0]         perim_in, perim_ff;
   logic [AREA_W-1:0]          area_out_ff;

   always_comb begin
      degen_in = area_ff[LAST] == '0;
      for (int i = 0; i < NQ; i++) begin
         if (degen_in)              w_in[i] = '0;
         else if (sat_ff[LAST][i])  w_in[i] = WMAX;
         else                       w_in[i] = WEIGHT_W'(q_ff[LAST][i]);
      end
      w2_raw = ONE_W - W2_W'(w_in[0]) - W2_W'(w_in[1]);
      if (degen_in)            w2_in = '0;
      else if (w2_raw > W2_MAX) w2_in = WMAX;
      else if (w2_raw < W2_MIN) w2_in = WEIGHT_W'(W2_MIN);
      else                      w2_in = WEIGHT_W'(w2_raw);
      for (int k = 0; k < NV; k++) begin
         dist_in[k] = DIST_W'(root_ff[LAST][tribary_pkg::LANE_D0+k]);
      end
      perim_in = PERIM_W'(root_ff[LAST][tribary_pkg::LANE_S01])
               + PERIM_W'(root_ff[LAST][tribary_pkg::LANE_S02])
               + PERIM_W'(root_ff[LAST][tribary_pkg::LANE_S12]);
   end

   always_ff @(posedge clock) begin
      if (rdy[FIN]) begin
         degen_ff    <= degen_in;
         w_ff        <= w_in;
         w2_ff       <= w2_in;
         dist_ff     <= dist_in;
         perim_ff    <= perim_in;
         area_out_ff <= area_ff[LAST];
      end
   end

   assign rsp_tvalid = vld_ff[FIN];
   assign rsp_tuser  = degen_ff;
   assign rsp_tdata  = {{(OUT_W-FIELDS_W){1'b0}}, perim_ff, area_out_ff,
                        dist_ff[2], dist_ff[1], dist_ff[0], w2_ff, w_ff[1], w_ff[0]};

endmodule

// File: design/tribary_checker.sv
// ----------------------------------------------------------------------------
// Triangle barycentric port checker
// Watches the top-level ports and flags broken result behavior.
// ----------------------------------------------------------------------------
module tribary_checker #(
   parameter int COORD_BITS       = 16,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic [((3*(WEIGHT_FRAC_BITS+3)+3*(COORD_BITS+2)+(2*COORD_BITS+4)
                 +(COORD_BITS+4)+7)/8)*8-1:0]   rsp_tdata,
   input logic                                  rsp_tuser,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready
);

   localparam int WW     = WEIGHT_FRAC_BITS + 3;
   localparam int DW     = COORD_BITS + 2;
   localparam int AW     = 2*COORD_BITS + 4;
   localparam int AREA_LO = 3*WW + 3*DW;

   logic [AW-1:0] area;
   logic [WW-1:0] w0, w1, w2;

   assign area = rsp_tdata[AREA_LO +: AW];
   assign w0   = rsp_tdata[0 +: WW];
   assign w1   = rsp_tdata[WW +: WW];
   assign w2   = rsp_tdata[2*WW +: WW];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((area == '0) == rsp_tuser))
      else $error("zero-area flag disagrees with area");

   a_zero_weights: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> w0 == '0 && w1 == '0 && w2 == '0)
      else $error("weights not zeroed for zero-area triangle");

   a_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !w0[WW-1] && !w1[WW-1])
      else $error("first two weights negative");

endmodule

bind triangle_barycentric_and_metrics tribary_checker #(
   .COORD_BITS       (COORD_BITS),
   .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
) u_tribary_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// File: tb/sv/triangle_barycentric_and_metrics_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle barycentric and metrics testbench
// Loads triangles through the csr_ port, streams query points on req_ and
// checks every rsp_ transfer against a local predictor, under several mixes
// of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module triangle_barycentric_and_metrics_tb;

   localparam int  CLK_HALF      = 2;
   localparam int  WFRAC         = 16;
   localparam longint WMAX       = (64'sd1 <<< (WFRAC + 2)) - 1;
   localparam longint WMIN       = -(64'sd1 <<< (WFRAC + 2));
   localparam int  DRAIN_CYCLES  = 40;
   localparam int  STALL_LIMIT   = 5000;

   typedef struct {
      logic [18:0] w0, w1, w2;
      logic [17:0] d0, d1, d2;
      logic [35:0] area;
      logic [19:0] perim;
      logic        degen;
   } metrics_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [31:0]  req_tdata = '0;           // point_x, point_y from the lowest bit up
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] rsp_tdata;                // weights, dists, area_doubled, perimeter
   logic         rsp_tuser;                // degenerate
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_wen = 1'b0;
   logic [tribary_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   // Local copy of the triangle, updated together with each csr_ write
   logic signed [15:0] vert_x [3];
   logic signed [15:0] vert_y [3];

   logic [31:0]  point_q [$];              // points waiting to be sent
   metrics_type  metrics_q [$];            // predicted results in order
   int           send_idle = 0;
   int           recv_idle = 0;
   bit           hold_points = 1'b0;
   int           fail_count = 0;
   int           point_count = 0;
   int           degen_count = 0;
   int           stall_cycles = 0;
   bit           req_fire, rsp_fire;
   metrics_type  got, want;

   triangle_barycentric_and_metrics dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    -= root + bitv;
            root  = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned span(longint dx, longint dy);
      return floor_sqrt(longint'(dx * dx + dy * dy));
   endfunction

   function automatic longint unsigned abs_cross(longint ax, longint ay,
                                                 longint bx, longint by);
      longint c;
      c = ax * by - ay * bx;
      return (c < 0) ? -c : c;
   endfunction

   // floor(num * 2^WFRAC / den), clipped to the top weight
   function automatic longint weight_quot(longint unsigned num, longint unsigned den);
      longint unsigned q, r;
      q = num / den;
      r = num % den;
      if (q > (WMAX >> WFRAC)) return WMAX;
      for (int i = 0; i < WFRAC; i++) begin
         r <<= 1;
         q <<= 1;
         if (r >= den) begin
            r -= den;
            q |= 1;
         end
      end
      return (q > WMAX) ? WMAX : longint'(q);
   endfunction

   function automatic metrics_type predict_metrics(logic [31:0] pt);
      metrics_type     m;
      longint          px, py, w0, w1, w2;
      longint          x [3], y [3];
      longint unsigned full, n0, n1;
      px = longint'($signed(pt[15:0]));
      py = longint'($signed(pt[31:16]));
      for (int k = 0; k < 3; k++) begin
         x[k] = longint'(vert_x[k]);
         y[k] = longint'(vert_y[k]);
      end
      full = abs_cross(x[1]-x[0], y[1]-y[0], x[2]-x[0], y[2]-y[0]);
      w0 = 0; w1 = 0; w2 = 0;
      if (full != 0) begin
         n0 = abs_cross(x[2]-px, y[2]-py, x[1]-px, y[1]-py);
         n1 = abs_cross(x[2]-px, y[2]-py, x[0]-px, y[0]-py);
         w0 = weight_quot(n0, full);
         w1 = weight_quot(n1, full);
         w2 = (64'sd1 <<< WFRAC) - w0 - w1;
         if (w2 > WMAX) w2 = WMAX;
         if (w2 < WMIN) w2 = WMIN;
      end
      m.w0    = w0[18:0];
      m.w1    = w1[18:0];
      m.w2    = w2[18:0];
      m.d0    = 18'(span(px - x[0], py - y[0]));
      m.d1    = 18'(span(px - x[1], py - y[1]));
      m.d2    = 18'(span(px - x[2], py - y[2]));
      m.area  = full[35:0];
      m.perim = 20'(span(x[1]-x[0], y[1]-y[0]) + span(x[2]-x[0], y[2]-y[0])
                    + span(x[2]-x[1], y[2]-y[1]));
      m.degen = (full == 0);
      return m;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: present the oldest pending point, hold it until the transfer
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      req_fire = req_tvalid && req_tready;
      if (req_fire) begin
         metrics_q.push_back(predict_metrics(req_tdata));
         void'(point_q.pop_front());
         point_count++;
      end
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_fire)) begin
         if (point_q.size() > 0 && !hold_points && $urandom_range(99) >= send_idle) begin
            req_tvalid <= 1'b1;
            req_tdata  <= point_q[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: random backpressure, field checks, stall watchdog
   // ------------------------------------------------------------------------
   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_fire = rsp_tvalid && rsp_tready;
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle);
      if (rsp_fire) begin
         got.w0    = rsp_tdata[18:0];
         got.w1    = rsp_tdata[37:19];
         got.w2    = rsp_tdata[56:38];
         got.d0    = rsp_tdata[74:57];
         got.d1    = rsp_tdata[92:75];
         got.d2    = rsp_tdata[110:93];
         got.area  = rsp_tdata[146:111];
         got.perim = rsp_tdata[166:147];
         got.degen = rsp_tuser;
         if (metrics_q.size() == 0) begin
            $error("unexpected result transfer");
            fail_count++;
         end else begin
            want = metrics_q.pop_front();
            if (want.degen) degen_count++;
            check_field("weight0", want.w0, got.w0);
            check_field("weight1", want.w1, got.w1);
            check_field("weight2", want.w2, got.w2);
            check_field("dist0", want.d0, got.d0);
            check_field("dist1", want.d1, got.d1);
            check_field("dist2", want.d2, got.d2);
            check_field("area_doubled", want.area, got.area);
            check_field("perimeter", want.perim, got.perim);
            check_field("degenerate", want.degen, got.degen);
         end
      end
      // count cycles with work outstanding but no transfer on either side
      if (req_fire || rsp_fire || (point_q.size() == 0 && metrics_q.size() == 0))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic wait_idle();
      while (point_q.size() > 0 || metrics_q.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all six coordinates back to back, then drop the enable
   task automatic load_triangle(int x0, int y0, int x1, int y1, int x2, int y2);
      logic [15:0] vals [tribary_pkg::NUM_REGS];
      vals = '{16'(x0), 16'(y0), 16'(x1), 16'(y1), 16'(x2), 16'(y2)};
      for (int i = 0; i < tribary_pkg::NUM_REGS; i++) begin
         @(posedge clock);
         csr_wen   <= 1'b1;
         csr_index <= tribary_pkg::csr_reg_type'(i);
         csr_wdata <= vals[i];
         if (i % 2 == 0) vert_x[i/2] = vals[i];
         else            vert_y[i/2] = vals[i];
      end
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic add_point(int px, int py);
      point_q.push_back({py[15:0], px[15:0]});
   endtask

   // random triangle: small, full range or collinear
   task automatic random_triangle();
      int x [3], y [3], kind, lim, t;
      kind = $urandom_range(9);
      lim  = (kind < 4) ? 300 : 32767;
      for (int k = 0; k < 3; k++) begin
         x[k] = $urandom_range(2*lim) - lim;
         y[k] = $urandom_range(2*lim) - lim;
      end
      if (kind == 9) begin
         t = $urandom_range(4);
         x[2] = x[0] + ((x[1] - x[0]) * t) / 4;
         y[2] = y[0] + ((y[1] - y[0]) * t) / 4;
         if ((x[1] - x[0]) % 4 != 0 || (y[1] - y[0]) % 4 != 0) begin
            x[2] = x[0];
            y[2] = y[0];
         end
      end
      load_triangle(x[0], y[0], x[1], y[1], x[2], y[2]);
   endtask

   // mostly points inside the triangle, the rest anywhere
   task automatic random_points(int count);
      int a, b, px, py;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) < 7) begin
            a = $urandom_range(256);
            b = $urandom_range(256 - a);
            px = vert_x[0] + ((vert_x[1] - vert_x[0]) * a + (vert_x[2] - vert_x[0]) * b) / 256;
            py = vert_y[0] + ((vert_y[1] - vert_y[0]) * a + (vert_y[2] - vert_y[0]) * b) / 256;
            add_point(px, py);
         end else begin
            add_point($urandom_range(65535), $urandom_range(65535));
         end
      end
   endtask

   initial begin
      int idle_mix [4][2];
      idle_mix = '{'{0, 0}, '{65, 0}, '{0, 65}, '{33, 33}};
      for (int k = 0; k < 3; k++) begin
         vert_x[k] = '0;
         vert_y[k] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero-area triangle straight out of reset, corner points
      add_point(-32768, -32768);
      add_point(32767, 32767);
      add_point(-32768, 32767);
      add_point(32767, -32768);
      add_point(0, 0);
      wait_idle();

      // largest triangle, vertices and extremes as query points
      load_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
      add_point(-32768, -32768);
      add_point(32767, -32768);
      add_point(-32768, 32767);
      add_point(32767, 32767);
      add_point(0, 0);
      add_point(-10923, -10923);
      add_point(-1, -1);
      wait_idle();

      // tiny triangle, far points saturate the weights
      load_triangle(0, 0, 1, 0, 0, 1);
      add_point(0, 0);
      add_point(1, 1);
      add_point(32767, 32767);
      add_point(-32768, -32768);
      add_point(-32768, 32767);
      wait_idle();

      // collinear vertices: degenerate with nonzero perimeter
      load_triangle(-100, -100, 0, 0, 100, 100);
      add_point(5, -7);
      add_point(32767, -32768);
      wait_idle();

      // Random: each idling mix over three triangles
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = idle_mix[ph][0];
         recv_idle = idle_mix[ph][1];
         for (int t = 0; t < 3; t++) begin
            random_triangle();
            random_points(60);
            // hold the sender until every outstanding result is back
            if (t == 1) begin
               repeat (20) @(posedge clock);
               hold_points = 1'b1;
               while (metrics_q.size() > 0 || req_tvalid) @(posedge clock);
               hold_points = 1'b0;
            end
            wait_idle();
         end
      end

      $display("Covered %0d query points (%0d on zero-area triangles) over", point_count,
               degen_count);
      $display("  extreme, tiny, collinear and random triangles with mixed idling.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
